// ===== rtl/core/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the radio frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam logic [1:0] REG_CODE_DELIM  = 2'd0;
	localparam logic [1:0] REG_START_DELIM = 2'd1;
	localparam logic [1:0] REG_CHECK_DELIM = 2'd2;
	localparam logic [1:0] REG_END_DELIM   = 2'd3;

	localparam logic [7:0] CODE_DELIM_RST  = 8'd35;
	localparam logic [7:0] START_DELIM_RST = 8'd36;
	localparam logic [7:0] CHECK_DELIM_RST = 8'd38;
	localparam logic [7:0] END_DELIM_RST   = 8'd59;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_NINE = 8'd57;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_CODE,
		MODE_PAYLOAD,
		MODE_CHECK
	} mode_t;

	typedef enum logic [1:0] {
		EM_RUN,
		EM_READ,
		EM_LOAD,
		EM_EMPTY
	} emit_t;

	typedef struct packed {
		logic [7:0] code_delim;
		logic [7:0] start_delim;
		logic [7:0] check_delim;
		logic [7:0] end_delim;
	} delim_t;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic       fire;
		logic       empty;
		logic [7:0] code;
	} frame_done_t;

endpackage

// ===== rtl/core/rfp_if.sv =====
// ----------------------------------------------------------------------------
// rfp_if
// Channel interfaces of the radio frame parser: byte in, result out, config.
// ----------------------------------------------------------------------------
interface rfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       is_last;
	logic       is_empty;
	logic [7:0] packet_code;
	modport source (output valid, output payload_byte, output is_last,
		output is_empty, output packet_code, input ready);
	modport sink (input valid, input payload_byte, input is_last,
		input is_empty, input packet_code, output ready);
endinterface

interface rfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rfp_parse.sv =====
// ----------------------------------------------------------------------------
// rfp_parse
// Section tracking, payload store writes, length digits and frame check.
// ----------------------------------------------------------------------------
module rfp_parse
	import rfp_pkg::*;
#(
	parameter int PAYLOAD_MAX  = 32,
	parameter int CHECK_DIGITS = 3,
	parameter int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
	parameter int CW = $clog2(PAYLOAD_MAX + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  delim_t            delim,
	output store_wr_t         wr,
	output logic [AW-1:0]     wr_addr,
	output frame_done_t       done,
	output logic [CW-1:0]     done_len
);

	mode_t         mode_q, mode_d;
	logic [7:0]    cur_code_q, cur_code_d;
	logic [7:0]    dlv_code_q, dlv_code_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] text_q, text_d;
	logic          zero_seen_q, zero_seen_d;
	logic          ovf_q, ovf_d;
	logic [9:0]    check_q, check_d;
	logic [1:0]    digits_q, digits_d;
	logic          stopped_q, stopped_d;

	logic is_code, is_start, is_check, is_end, is_plain, is_digit, pass;
	logic [9:0] digit_val;

	assign is_code  = rx_byte == delim.code_delim;
	assign is_start = !is_code && rx_byte == delim.start_delim;
	assign is_check = !is_code && !is_start && rx_byte == delim.check_delim;
	assign is_end   = !is_code && !is_start && !is_check && rx_byte == delim.end_delim;
	assign is_plain = !is_code && !is_start && !is_check && !is_end;
	assign is_digit = rx_byte >= ASCII_ZERO && rx_byte <= ASCII_NINE;
	assign digit_val = {6'd0, 4'(rx_byte - ASCII_ZERO)};
	assign pass = !ovf_q && check_q == 10'(text_q) && cur_code_q != dlv_code_q;

	assign wr_addr  = count_q[AW-1:0];
	assign done_len = text_q;

	always_comb begin
		mode_d      = mode_q;
		cur_code_d  = cur_code_q;
		dlv_code_d  = dlv_code_q;
		count_d     = count_q;
		text_d      = text_q;
		zero_seen_d = zero_seen_q;
		ovf_d       = ovf_q;
		check_d     = check_q;
		digits_d    = digits_q;
		stopped_d   = stopped_q;
		wr.en       = 1'b0;
		wr.data     = rx_byte;
		done.fire   = 1'b0;
		done.empty  = text_q == '0;
		done.code   = cur_code_q;
		if (accept) begin
			if (is_code) begin
				mode_d      = MODE_CODE;
				count_d     = '0;
				text_d      = '0;
				zero_seen_d = 1'b0;
				ovf_d       = 1'b0;
				check_d     = '0;
				digits_d    = '0;
				stopped_d   = 1'b0;
			end else if (is_start) begin
				if (mode_q == MODE_CODE) begin
					mode_d = MODE_PAYLOAD;
				end
			end else if (is_check) begin
				if (mode_q == MODE_PAYLOAD) begin
					mode_d = MODE_CHECK;
				end
			end else if (is_end) begin
				if (mode_q == MODE_CHECK) begin
					mode_d = MODE_IDLE;
					if (pass) begin
						dlv_code_d = cur_code_q;
						done.fire  = 1'b1;
					end
				end
			end else begin
				case (mode_q)
					MODE_CODE: begin
						cur_code_d = rx_byte;
					end
					MODE_PAYLOAD: begin
						if (count_q < CW'(PAYLOAD_MAX)) begin
							wr.en   = 1'b1;
							count_d = count_q + 1'b1;
							if (!zero_seen_q) begin
								if (rx_byte == 8'd0) begin
									zero_seen_d = 1'b1;
								end else begin
									text_d = text_q + 1'b1;
								end
							end
						end else begin
							ovf_d = 1'b1;
						end
					end
					MODE_CHECK: begin
						if (!stopped_q && digits_q < 2'(CHECK_DIGITS)) begin
							if (is_digit) begin
								check_d  = 10'(check_q * 10'd10) + digit_val;
								digits_d = digits_q + 1'b1;
							end else begin
								stopped_d = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cur_code_q  <= '0;
			dlv_code_q  <= '0;
			count_q     <= '0;
			text_q      <= '0;
			zero_seen_q <= 1'b0;
			ovf_q       <= 1'b0;
			check_q     <= '0;
			digits_q    <= '0;
			stopped_q   <= 1'b0;
		end else begin
			mode_q      <= mode_d;
			cur_code_q  <= cur_code_d;
			dlv_code_q  <= dlv_code_d;
			count_q     <= count_d;
			text_q      <= text_d;
			zero_seen_q <= zero_seen_d;
			ovf_q       <= ovf_d;
			check_q     <= check_d;
			digits_q    <= digits_d;
			stopped_q   <= stopped_d;
		end
	end

	a_text_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		text_q <= count_q) else $error("text length beyond stored bytes");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CW'(PAYLOAD_MAX)) else $error("overflow before store full");

	a_fire_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		done.fire |-> mode_q == MODE_CHECK && accept) else $error("frame done outside check");

	a_fire_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		done.fire |=> dlv_code_q == $past(cur_code_q) && mode_q == MODE_IDLE)
		else $error("delivered code not updated");

endmodule

// ===== rtl/core/radio_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// radio_frame_parser_top
// Byte-serial packet deframer with a payload store and result read-out.
//
//   channel   dir   handshake      payload
//   rx        in    valid/ready    rx_byte
//   pkt       out   valid/ready    payload_byte, is_last, is_empty, packet_code
//   cfg       in    valid/ready    index, data (delimiter registers)
//
// rx is held off while a packet is read out
// read-out walks the store with one registered read per result, then loads the
// output register; the next read waits until that result is loaded
// an empty packet sends one is_empty item; stalled pkt holds the output register
// the last result may wait in the output register while new bytes are taken
// reset clears control state only; the store needs no clearing pass
// ----------------------------------------------------------------------------
module radio_frame_parser_top
	import rfp_pkg::*;
#(
	parameter int PAYLOAD_MAX  = 32,
	parameter int CHECK_DIGITS = 3
) (
	input  logic  clk,
	input  logic  arst_n,
	rfp_byte_if.sink  rx,
	rfp_out_if.source pkt,
	rfp_cfg_if.sink   cfg
);

	localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int CW = $clog2(PAYLOAD_MAX + 1);

	delim_t        delim_q;
	store_wr_t     wr;
	logic [AW-1:0] wr_addr;
	frame_done_t   done;
	logic [CW-1:0] done_len;

	emit_t         state_q, state_d;
	logic [CW-1:0] rd_cnt_q;
	logic [CW-1:0] len_q;
	logic [7:0]    code_q;
	logic [7:0]    rdata_s1;
	logic [7:0]    store_mem [PAYLOAD_MAX];

	logic          ovalid_q;
	logic [7:0]    obyte_q;
	logic          olast_q;
	logic          oempty_q;
	logic [7:0]    ocode_q;

	logic accept, slot_free, rd_en, load_byte, load_empty, rd_last;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q.code_delim  <= CODE_DELIM_RST;
			delim_q.start_delim <= START_DELIM_RST;
			delim_q.check_delim <= CHECK_DELIM_RST;
			delim_q.end_delim   <= END_DELIM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CODE_DELIM:  delim_q.code_delim  <= cfg.data;
				REG_START_DELIM: delim_q.start_delim <= cfg.data;
				REG_CHECK_DELIM: delim_q.check_delim <= cfg.data;
				REG_END_DELIM:   delim_q.end_delim   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign accept = rx.valid && rx.ready;

	rfp_parse #(
		.PAYLOAD_MAX  (PAYLOAD_MAX),
		.CHECK_DIGITS (CHECK_DIGITS),
		.AW           (AW),
		.CW           (CW)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx.rx_byte),
		.delim    (delim_q),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.done     (done),
		.done_len (done_len)
	);

	// payload store
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= store_mem[rd_cnt_q[AW-1:0]];
		end
	end

	assign slot_free = !ovalid_q || pkt.ready;
	assign rd_last   = (rd_cnt_q + 1'b1) == len_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			EM_RUN: begin
				if (done.fire) begin
					state_d = done.empty ? EM_EMPTY : EM_READ;
				end
			end
			EM_READ: begin
				state_d = EM_LOAD;
			end
			EM_LOAD: begin
				if (slot_free) begin
					state_d = rd_last ? EM_RUN : EM_READ;
				end
			end
			EM_EMPTY: begin
				if (slot_free) begin
					state_d = EM_RUN;
				end
			end
			default: begin
				state_d = EM_RUN;
			end
		endcase
	end

	always_comb begin
		rx.ready   = 1'b0;
		rd_en      = 1'b0;
		load_byte  = 1'b0;
		load_empty = 1'b0;
		case (state_q)
			EM_RUN:   rx.ready   = 1'b1;
			EM_READ:  rd_en      = 1'b1;
			EM_LOAD:  load_byte  = slot_free;
			EM_EMPTY: load_empty = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EM_RUN;
			rd_cnt_q <= '0;
			len_q    <= '0;
			code_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done.fire) begin
				rd_cnt_q <= '0;
				len_q    <= done_len;
				code_q   <= done.code;
			end else if (load_byte) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (load_byte || load_empty) begin
				ovalid_q <= 1'b1;
			end else if (pkt.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_byte) begin
			obyte_q  <= rdata_s1;
			olast_q  <= rd_last;
			oempty_q <= 1'b0;
			ocode_q  <= code_q;
		end else if (load_empty) begin
			obyte_q  <= 8'd0;
			olast_q  <= 1'b1;
			oempty_q <= 1'b1;
			ocode_q  <= code_q;
		end
	end

	assign pkt.valid        = ovalid_q;
	assign pkt.payload_byte = obyte_q;
	assign pkt.is_last      = olast_q;
	assign pkt.is_empty     = oempty_q;
	assign pkt.packet_code  = ocode_q;

	a_fire_when_run: assert property (@(posedge clk) disable iff (!arst_n)
		done.fire |-> state_q == EM_RUN) else $error("frame done during read-out");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EM_READ || state_q == EM_LOAD) |-> rd_cnt_q < len_q)
		else $error("read-out index beyond payload");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(load_byte || load_empty) |=> ovalid_q) else $error("loaded item not shown");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && oempty_q) |-> olast_q) else $error("empty item without last");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radio_frame_parser_top. A directed table of frames
// comes first, then random frames under several delimiter settings, with
// random gaps and stalls on both channels outside one calm phase. Every
// accepted byte is run through a bench-side deframer, and each packet byte
// that comes out is compared against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
	import rfp_pkg::*;

	localparam int PAYLOAD_MAX  = 32;
	localparam int CHECK_DIGITS = 3;
	localparam int SETTLE       = 100;
	localparam int LIMIT        = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic [7:0] code;
	} delivery_t;

	typedef struct {
		logic [7:0] b;
		int         typed_n;
		delivery_t  typed;
	} stim_t;

	localparam delivery_t NO_PKT = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rfp_byte_if rx ();
	rfp_out_if  pkt ();
	rfp_cfg_if  cfg ();

	radio_frame_parser_top #(
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.CHECK_DIGITS(CHECK_DIGITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.pkt   (pkt),
		.cfg   (cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bench copy of the deframer state
	delim_t     delims = '{CODE_DELIM_RST, START_DELIM_RST, CHECK_DELIM_RST, END_DELIM_RST};
	mode_t      section = MODE_IDLE;
	logic [7:0] cur_code = '0;
	logic [7:0] dlv_code = '0;
	logic [7:0] store [PAYLOAD_MAX];
	logic [5:0] pay_cnt = '0;
	logic [5:0] txt_len = '0;
	logic       zero_seen = 1'b0;
	logic       overflowed = 1'b0;
	logic [9:0] chk_val = '0;
	logic [1:0] dig_cnt = '0;
	logic       dig_stop = 1'b0;

	delivery_t burst [$];
	delivery_t due [$];
	stim_t     tx_q [$];
	stim_t     rx_tag;
	stim_t     plan [28];

	int errors = 0;
	int cyc = 0;
	int queued = 0;
	bit calm = 1'b0;

	task automatic flag(input string what);
		$display("ERROR @%0t: %s", $time, what);
		errors++;
	endtask

	function automatic bit is_delim(input logic [7:0] v);
		return v == delims.code_delim || v == delims.start_delim ||
			v == delims.check_delim || v == delims.end_delim;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (is_delim(v));
		return v;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		burst.delete();
		if (b == delims.code_delim) begin
			section = MODE_CODE;
			pay_cnt = '0;
			txt_len = '0;
			zero_seen = 1'b0;
			overflowed = 1'b0;
			chk_val = '0;
			dig_cnt = '0;
			dig_stop = 1'b0;
		end else if (b == delims.start_delim) begin
			if (section == MODE_CODE) section = MODE_PAYLOAD;
		end else if (b == delims.check_delim) begin
			if (section == MODE_PAYLOAD) section = MODE_CHECK;
		end else if (b == delims.end_delim) begin
			if (section == MODE_CHECK) begin
				section = MODE_IDLE;
				if (!overflowed && chk_val == {4'b0, txt_len} && cur_code != dlv_code) begin
					dlv_code = cur_code;
					if (txt_len == 0)
						burst.push_back('{8'h00, 1'b1, 1'b1, cur_code});
					else
						for (int k = 0; k < txt_len; k++)
							burst.push_back('{store[k], (k + 1 == txt_len), 1'b0, cur_code});
				end
			end
		end else begin
			case (section)
				MODE_CODE: cur_code = b;
				MODE_PAYLOAD: begin
					if (pay_cnt < PAYLOAD_MAX) begin
						store[pay_cnt] = b;
						pay_cnt++;
						if (!zero_seen) begin
							if (b == 8'h00) zero_seen = 1'b1;
							else txt_len++;
						end
					end else begin
						overflowed = 1'b1;
					end
				end
				MODE_CHECK: begin
					if (!dig_stop && dig_cnt < CHECK_DIGITS) begin
						if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
							chk_val = 10'(chk_val * 10'd10 + 10'(b - ASCII_ZERO));
							dig_cnt++;
						end else begin
							dig_stop = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	endfunction

	task automatic write_delim(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_CODE_DELIM:  delims.code_delim = val;
			REG_START_DELIM: delims.start_delim = val;
			REG_CHECK_DELIM: delims.check_delim = val;
			REG_END_DELIM:   delims.end_delim = val;
			default: ;
		endcase
	endtask

	task automatic set_delims(input delim_t d);
		write_delim(REG_CODE_DELIM, d.code_delim);
		write_delim(REG_START_DELIM, d.start_delim);
		write_delim(REG_CHECK_DELIM, d.check_delim);
		write_delim(REG_END_DELIM, d.end_delim);
	endtask

	task automatic drain();
		while (tx_q.size() != 0 || rx.valid || due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly well-formed frames with random content, some noise and breakage
	task automatic fill_phase(input int n);
		logic [7:0] fr [$];
		logic [7:0] b;
		int len, zero_at, tl, style, val;
		queued = 0;
		while (queued < n) begin
			fr.delete();
			fr.push_back(delims.code_delim);
			repeat ($urandom_range(0, 2)) fr.push_back(plain_byte());
			fr.push_back(delims.start_delim);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(PAYLOAD_MAX - 2, PAYLOAD_MAX + 2)
				: $urandom_range(0, 8);
			zero_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : -1;
			tl = -1;
			for (int i = 0; i < len; i++) begin
				b = (i == zero_at && !is_delim(8'h00)) ? 8'h00 : plain_byte();
				if (b == 8'h00 && tl < 0 && i < PAYLOAD_MAX) tl = i;
				fr.push_back(b);
			end
			if (tl < 0) tl = (len > PAYLOAD_MAX) ? PAYLOAD_MAX : len;
			fr.push_back(delims.check_delim);
			style = $urandom_range(0, 9);
			val = (style == 7) ? $urandom_range(0, 999) : tl;
			if (style == 8) begin
				fr.push_back(ASCII_ZERO + 8'(val / 100));
				fr.push_back(ASCII_ZERO + 8'((val / 10) % 10));
				fr.push_back(ASCII_ZERO + 8'(val % 10));
				fr.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
			end else if (!(style == 6 && val == 0)) begin
				if (val >= 100) fr.push_back(ASCII_ZERO + 8'(val / 100));
				if (val >= 10) fr.push_back(ASCII_ZERO + 8'((val / 10) % 10));
				fr.push_back(ASCII_ZERO + 8'(val % 10));
			end
			if (style == 9) begin
				do b = plain_byte(); while (b >= ASCII_ZERO && b <= ASCII_NINE);
				fr.push_back(b);
				fr.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
			end
			fr.push_back(delims.end_delim);
			if ($urandom_range(0, 5) == 0)
				fr.insert($urandom_range(0, fr.size()), 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 11) == 0) void'(fr.pop_back());
			foreach (fr[i]) tx_q.push_back('{fr[i], -1, NO_PKT});
			queued += fr.size();
		end
	endtask

	initial begin
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		pkt.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("radio_frame_parser_top verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
		end else if (!rx.valid || rx.ready) begin
			if (tx_q.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
				rx.valid <= 1'b1;
				rx.rx_byte <= tx_q[0].b;
				rx_tag <= tx_q.pop_front();
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) pkt.ready <= 1'b0;
		else pkt.ready <= calm || ($urandom_range(0, 99) >= 34);
	end

	always @(posedge clk) begin
		if (arst_n && rx.valid && rx.ready) begin
			deframe_byte(rx.rx_byte);
			if (rx_tag.typed_n < 0) foreach (burst[i]) due.push_back(burst[i]);
			else if (rx_tag.typed_n == 1) due.push_back(rx_tag.typed);
		end
	end

	always @(posedge clk) begin
		delivery_t got, want;
		if (arst_n && pkt.valid && pkt.ready) begin
			got = '{pkt.payload_byte, pkt.is_last, pkt.is_empty, pkt.packet_code};
			if (due.size() == 0) begin
				flag($sformatf("unexpected item byte=%h last=%b empty=%b code=%h",
					got.data, got.last, got.empty, got.code));
			end else begin
				want = due.pop_front();
				if (got.data !== want.data || got.last !== want.last ||
					got.empty !== want.empty || got.code !== want.code)
					flag($sformatf("item byte=%h/%h last=%b/%b empty=%b/%b code=%h/%h",
						got.data, want.data, got.last, want.last,
						got.empty, want.empty, got.code, want.code));
			end
		end
	end

	initial begin
		delim_t d;
		plan = '{
			'{8'h78, 0, NO_PKT},
			'{END_DELIM_RST, 0, NO_PKT},
			'{CODE_DELIM_RST, 0, NO_PKT},
			'{8'h41, 0, NO_PKT},
			'{START_DELIM_RST, 0, NO_PKT},
			'{CHECK_DELIM_RST, 0, NO_PKT},
			'{ASCII_ZERO, 0, NO_PKT},
			'{END_DELIM_RST, 1, '{8'h00, 1'b1, 1'b1, 8'h41}},
			'{CODE_DELIM_RST, -1, NO_PKT},
			'{8'h42, -1, NO_PKT},
			'{START_DELIM_RST, -1, NO_PKT},
			'{8'h68, -1, NO_PKT},
			'{8'hFF, -1, NO_PKT},
			'{8'h00, -1, NO_PKT},
			'{8'h55, -1, NO_PKT},
			'{CHECK_DELIM_RST, -1, NO_PKT},
			'{8'h32, -1, NO_PKT},
			'{END_DELIM_RST, -1, NO_PKT},
			'{CODE_DELIM_RST, 0, NO_PKT},
			'{START_DELIM_RST, 0, NO_PKT},
			'{CHECK_DELIM_RST, 0, NO_PKT},
			'{END_DELIM_RST, 0, NO_PKT},
			'{CODE_DELIM_RST, 0, NO_PKT},
			'{8'hFF, 0, NO_PKT},
			'{START_DELIM_RST, 0, NO_PKT},
			'{8'h00, 0, NO_PKT},
			'{CHECK_DELIM_RST, 0, NO_PKT},
			'{END_DELIM_RST, 1, '{8'h00, 1'b1, 1'b1, 8'hFF}}
		};
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		repeat (4) @(posedge clk);

		foreach (plan[i]) tx_q.push_back(plan[i]);
		drain();
		fill_phase(28);
		drain();

		set_delims('{8'h00, 8'hFF, 8'h7F, 8'h80});
		fill_phase(28);
		drain();

		calm = 1'b1;
		set_delims('{8'hFF, 8'h00, 8'h01, 8'hFE});
		fill_phase(28);
		drain();
		calm = 1'b0;

		// start, check and end share one value
		d.start_delim = 8'($urandom_range(0, 255));
		d.check_delim = d.start_delim;
		d.end_delim = d.start_delim;
		do d.code_delim = 8'($urandom_range(0, 255)); while (d.code_delim == d.start_delim);
		set_delims(d);
		fill_phase(10);
		drain();

		do d = $urandom(); while (d.code_delim == d.start_delim ||
			d.code_delim == d.check_delim || d.code_delim == d.end_delim ||
			d.start_delim == d.check_delim || d.start_delim == d.end_delim ||
			d.check_delim == d.end_delim);
		set_delims(d);
		fill_phase(28);
		drain();

		if (errors == 0)
			$display("radio_frame_parser_top verification clean");
		else
			$display("radio_frame_parser_top verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rfp_pkg.sv
rtl/core/rfp_if.sv
rtl/core/rfp_parse.sv
rtl/core/radio_frame_parser_top.sv
bench/tb.sv
